/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the head rotation search RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// Condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CLK(lbl, !(cond))
`endif

/* hw/rtl/hrgs_pkg.sv */
// Types, constants and the sine table of the head rotation grid search.
// No dependencies; used by every RTL module of the block.
package hrgs_pkg;

  localparam int COORD_BITS     = 12;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TF             = TRIG_FRAC_BITS;

  localparam int ANG_W   = 8;
  localparam int ERR_W   = 41;
  localparam int TRIG_W  = TF + 2;
  localparam int PROD_W  = 2 * TRIG_W;
  localparam int Q3_W    = 3 * TRIG_W + 1;
  localparam int COEF_W  = TF + 3;
  localparam int MX_W    = COEF_W + COORD_BITS + 1;
  localparam int U_W     = COORD_BITS + 8;
  localparam int SQ_W    = 2 * U_W;
  localparam int SUM_W   = SQ_W + 3;
  localparam int PIPE_D  = 8;
  localparam int NPTS    = 6;

  localparam int IN_DATA_W  = ((NPTS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * ANG_W + ERR_W + 7) / 8) * 8;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  localparam logic ACT_UPDATE   = 1'b0;
  localparam logic ACT_ESTIMATE = 1'b1;

  typedef logic signed [ANG_W-1:0]  angle_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef trig_t sin_tab_t [0:90];

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FINISH} state_t;
  typedef enum logic [1:0] {STG_COARSE, STG_MID, STG_FINE} stage_t;

  typedef struct packed {
    angle_t a3;
    angle_t a2;
    angle_t a1;
  } tri_t;

  typedef struct packed {
    logic   capture;
    logic   update;
    logic   issue;
    logic   first;
    tri_t   ang;
    logic   load_out;
  } hrgs_cmd_t;

  typedef struct packed {
    logic busy;
    tri_t best;
  } hrgs_sts_t;

  // first angle in the lowest bits
  typedef struct packed {
    logic [ERR_W-1:0] err;
    angle_t           third;
    angle_t           second;
    angle_t           first;
  } hrgs_res_t;

  localparam angle_t SPAN_COARSE = 8'sd90;
  localparam angle_t SPAN_MID    = 8'sd10;
  localparam angle_t SPAN_FINE   = 8'sd4;
  localparam angle_t STEP_COARSE = 8'sd15;
  localparam angle_t STEP_MID    = 8'sd5;
  localparam angle_t STEP_FINE   = 8'sd1;

  function automatic angle_t stage_span(input stage_t s);
    case (s)
      STG_COARSE: return SPAN_COARSE;
      STG_MID:    return SPAN_MID;
      STG_FINE:   return SPAN_FINE;
      default:    return SPAN_FINE;
    endcase
  endfunction

  function automatic angle_t stage_step(input stage_t s);
    case (s)
      STG_COARSE: return STEP_COARSE;
      STG_MID:    return STEP_MID;
      STG_FINE:   return STEP_FINE;
      default:    return STEP_FINE;
    endcase
  endfunction

  // pi in Q30 and the Taylor divisors (2k)(2k+1)
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

  // Sine of 0..90 degrees, Q30 series rounded to TF fraction bits
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t           t;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    for (int d = 0; d <= 90; d++) begin
      x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k <= 8; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / TAYLOR_DIV[k];
        if (k[0]) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) sum = '0;
      if (unsigned'(sum) > Q30_ONE) sum = signed'(Q30_ONE);
      r    = (unsigned'(sum) + (64'd1 << (29 - TF))) >> (30 - TF);
      t[d] = signed'(r[TRIG_W-1:0]);
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // Sine of a whole degree in -256..255, folded onto the quarter table
  function automatic trig_t sin_deg(input logic signed [8:0] d);
    logic [8:0] m;
    logic       neg;
    logic [6:0] idx;
    trig_t      v;
    neg = d[8];
    m   = neg ? 9'(-d) : 9'(d);
    if (m <= 9'd90) begin
      idx = m[6:0];
    end else if (m <= 9'd180) begin
      idx = 7'(9'd180 - m);
    end else begin
      idx = 7'(m - 9'd180);
      neg = !neg;
    end
    v = SIN_TAB[idx];
    return neg ? -v : v;
  endfunction

  function automatic trig_t cos_deg(input logic signed [8:0] d);
    return sin_deg(9'sd90 - d);
  endfunction

endpackage

/* hw/rtl/head_rotation_grid_search_core.sv */
// Top level of the head rotation grid search.
// Depends on hrgs_pkg, hrgs_ctrl and hrgs_datapath.
//
// Usage:
//   Input words carry three observed face points in in_tdata and the action
//   in in_tuser. An update word moves the stored reference points a fifth of
//   the way toward the observed ones; the block stays idle and gives no output.
//   An estimate word starts a three-stage grid search over angle triples and
//   gives one output word: the best three angles and the residual score.
//   The scoring pipeline takes one triple a cycle and is eight stages deep;
//   it drains after each stage so the next grid is centred on the best so far.
//   An estimate scores 2197 + 125 + 729 = 3051 angle triples in all. Only
//   one word is in work at a time; in_tready is high while idle.
//   The output register holds a finished result while out_tready is low, and
//   the next word is accepted meanwhile; a second estimate waits at its end
//   until the register is free. Reset clears the reference points to zero and
//   empties the pipeline and output; no warm-up is needed.
module head_rotation_grid_search_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // left_eye_x, left_eye_y, right_eye_x, right_eye_y, nose_x, nose_y
  input  logic [hrgs_pkg::IN_DATA_W-1:0]       in_tdata,
  // action
  input  logic [0:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // first_angle, second_angle, third_angle, best_error, zero pad
  output logic [hrgs_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import hrgs_pkg::*;

  hrgs_cmd_t cmd;
  hrgs_sts_t sts;
  hrgs_res_t res;

  hrgs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  hrgs_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

  // Pack the result word, first angle lowest
  assign out_tdata = OUT_DATA_W'(res);

endmodule

/* hw/rtl/hrgs_ctrl.sv */
// Sequencer of the head rotation search: handshakes and the three grid stages.
// Depends on hrgs_pkg; drives hrgs_datapath through command and status structs.
`include "assert_macros.svh"
module hrgs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_action,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  input  hrgs_pkg::hrgs_sts_t sts,
  output hrgs_pkg::hrgs_cmd_t cmd
);
  import hrgs_pkg::*;

  state_t state_r, state_nxt;
  stage_t stage_r, stage_nxt;
  angle_t off1_r, off2_r, off3_r;
  angle_t off1_nxt, off2_nxt, off3_nxt;
  tri_t   cen_r, cen_nxt;
  logic   out_valid_r, out_valid_nxt;

  angle_t span, step, span_next;
  logic   last1, last2, last3, all_last;
  logic   accept;
  logic   in_span;

  assign span      = stage_span(stage_r);
  assign step      = stage_step(stage_r);
  assign span_next = stage_span(stage_t'(stage_r + 2'd1));
  assign last1     = (off1_r == span);
  assign last2     = (off2_r == span);
  assign last3     = (off3_r == span);
  assign all_last  = last1 && last2 && last3;
  assign accept    = in_tvalid && in_tready;
  assign in_span   = (off1_r >= -span) && (off1_r <= span) &&
                     (off2_r >= -span) && (off2_r <= span) &&
                     (off3_r >= -span) && (off3_r <= span);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == ACT_ESTIMATE)) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (all_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.busy) state_nxt = (stage_r == STG_FINE) ? ST_FINISH : ST_RUN;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    out_tvalid   = out_valid_r;
    cmd.capture  = accept;
    cmd.update   = accept && (in_action == ACT_UPDATE);
    cmd.issue    = (state_r == ST_RUN);
    cmd.first    = (off1_r == -span) && (off2_r == -span) && (off3_r == -span);
    cmd.ang.a1   = angle_t'(cen_r.a1 + off1_r);
    cmd.ang.a2   = angle_t'(cen_r.a2 + off2_r);
    cmd.ang.a3   = angle_t'(cen_r.a3 + off3_r);
    cmd.load_out = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  end

  // Loop counters, stage centre and result valid
  always_comb begin
    stage_nxt     = stage_r;
    off1_nxt      = off1_r;
    off2_nxt      = off2_r;
    off3_nxt      = off3_r;
    cen_nxt       = cen_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    case (state_r)
      ST_IDLE: begin
        stage_nxt = STG_COARSE;
        cen_nxt   = '0;
        off1_nxt  = -SPAN_COARSE;
        off2_nxt  = -SPAN_COARSE;
        off3_nxt  = -SPAN_COARSE;
      end
      ST_RUN: begin
        if (!last3) begin
          off3_nxt = angle_t'(off3_r + step);
        end else begin
          off3_nxt = -span;
          if (!last2) begin
            off2_nxt = angle_t'(off2_r + step);
          end else begin
            off2_nxt = -span;
            off1_nxt = angle_t'(off1_r + step);
          end
        end
      end
      ST_DRAIN: begin
        if (!sts.busy && (stage_r != STG_FINE)) begin
          stage_nxt = stage_t'(stage_r + 2'd1);
          cen_nxt   = sts.best;
          off1_nxt  = -span_next;
          off2_nxt  = -span_next;
          off3_nxt  = -span_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= STG_COARSE;
      off1_r      <= '0;
      off2_r      <= '0;
      off3_r      <= '0;
      cen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      off1_r      <= off1_nxt;
      off2_r      <= off2_nxt;
      off3_r      <= off3_nxt;
      cen_r       <= cen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_NEVER(a_load_over_full, cmd.load_out && out_valid_r && !out_tready)
  `ASSERT_CLK(a_issue_in_span, cmd.issue |-> in_span)

endmodule

/* hw/rtl/hrgs_datapath.sv */
// Datapath of the head rotation search: reference points, scoring pipeline,
// best-triple tracking and result register. Depends on hrgs_pkg.
`include "assert_macros.svh"
module hrgs_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [hrgs_pkg::IN_DATA_W-1:0]      in_data,
  input  hrgs_pkg::hrgs_cmd_t                 cmd,
  output hrgs_pkg::hrgs_sts_t                 sts,
  output hrgs_pkg::hrgs_res_t                 res
);
  import hrgs_pkg::*;

  localparam int DIV_N = COORD_BITS + 3;
  localparam int DIV_S = DIV_N + 2;
  localparam int DIV_P = DIV_N + DIV_S;
  localparam logic [DIV_P-1:0] DIV_M = DIV_P'(((64'd1 << DIV_S) + 64'd4) / 64'd5);
  localparam int W5 = MX_W + 1;
  localparam logic signed [PROD_W:0] RND_A = (PROD_W+1)'(1) <<< (TF - 1);
  localparam logic signed [Q3_W:0]   RND_B = (Q3_W+1)'(1) <<< (2 * TF - 1);
  localparam logic signed [W5-1:0]   RND_U = W5'(1) <<< (TF - 5);

  coord_t ref_r [NPTS];
  coord_t obs_r [NPTS];
  coord_t obs_in [NPTS];

  logic [PIPE_D-1:0] vld_r, first_r;
  tri_t              tag_r [PIPE_D];
  logic              take_first;

  trig_t s1_r, c1_r, s2_r, c2_r, s3_r, c3_r;
  logic signed [PROD_W-1:0] pa_r, pc_r, p13_r, qb_r, qd_r;
  trig_t                    c2d_r, s2d_r;
  logic signed [COEF_W-1:0] a2_r, cc2_r, a_r, b_r, c_r, d_r;
  logic signed [Q3_W-1:0]   bf_r, df_r;
  logic signed [MX_W-1:0]   m0_r [NPTS];
  logic signed [MX_W-1:0]   m1_r [NPTS];
  logic signed [U_W-1:0]    u_r [NPTS];
  logic [SQ_W-1:0]          sq_r [NPTS];
  logic [ERR_W-1:0]         sum_r;
  logic [ERR_W-1:0]         low_r;
  tri_t                     best_r;

  // Divide by five through a reciprocal multiply, exact over the input range
  function automatic coord_t div5(input logic [DIV_N-1:0] n);
    logic [DIV_P-1:0] p;
    p = DIV_P'(n) * DIV_M;
    return p[DIV_S +: COORD_BITS];
  endfunction

  // Unpack observed points, left eye first
  always_comb begin
    for (int q = 0; q < NPTS; q++) obs_in[q] = in_data[q*COORD_BITS +: COORD_BITS];
  end

  // Capture observations; move references a fifth of the way
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NPTS; q++) ref_r[q] <= '0;
    end else if (cmd.update) begin
      for (int q = 0; q < NPTS; q++) ref_r[q] <= div5(DIV_N'({ref_r[q], 2'b00}) + DIV_N'(obs_in[q]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) obs_r <= obs_in;
  end

  // Control of the scoring pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_D-2:0], cmd.issue};
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= {first_r[PIPE_D-2:0], cmd.first};
    tag_r[0] <= cmd.ang;
    for (int s = 1; s < PIPE_D; s++) tag_r[s] <= tag_r[s-1];
  end

  // Stage 0: sine and cosine lookups
  always_ff @(posedge clk) begin
    s1_r <= sin_deg(9'(cmd.ang.a1));
    c1_r <= cos_deg(9'(cmd.ang.a1));
    s2_r <= sin_deg(9'(cmd.ang.a2));
    c2_r <= cos_deg(9'(cmd.ang.a2));
    s3_r <= sin_deg(9'(cmd.ang.a3));
    c3_r <= cos_deg(9'(cmd.ang.a3));
  end

  // Stage 1: pairwise products
  always_ff @(posedge clk) begin
    pa_r  <= PROD_W'(c2_r) * PROD_W'(c1_r);
    pc_r  <= PROD_W'(s2_r) * PROD_W'(c1_r);
    p13_r <= PROD_W'(s1_r) * PROD_W'(s3_r);
    qb_r  <= PROD_W'(s2_r) * PROD_W'(c3_r);
    qd_r  <= PROD_W'(c2_r) * PROD_W'(c3_r);
    c2d_r <= c2_r;
    s2d_r <= s2_r;
  end

  // Stage 2: round a and c, form b and d in Q3
  always_ff @(posedge clk) begin
    a2_r  <= COEF_W'(((PROD_W+1)'(pa_r) + RND_A) >>> TF);
    cc2_r <= COEF_W'(((PROD_W+1)'(pc_r) + RND_A) >>> TF);
    bf_r  <= Q3_W'(c2d_r) * Q3_W'(p13_r) - (Q3_W'(qb_r) <<< TF);
    df_r  <= Q3_W'(s2d_r) * Q3_W'(p13_r) + (Q3_W'(qd_r) <<< TF);
  end

  // Stage 3: round b and d
  always_ff @(posedge clk) begin
    a_r <= a2_r;
    c_r <= cc2_r;
    b_r <= COEF_W'(((Q3_W+1)'(bf_r) + RND_B) >>> (2 * TF));
    d_r <= COEF_W'(((Q3_W+1)'(df_r) + RND_B) >>> (2 * TF));
  end

  // Stage 4: coefficient times reference coordinate
  always_ff @(posedge clk) begin
    for (int p = 0; p < 3; p++) begin
      m0_r[2*p]   <= MX_W'(a_r) * MX_W'(signed'({1'b0, ref_r[2*p]}));
      m1_r[2*p]   <= MX_W'(b_r) * MX_W'(signed'({1'b0, ref_r[2*p+1]}));
      m0_r[2*p+1] <= MX_W'(c_r) * MX_W'(signed'({1'b0, ref_r[2*p]}));
      m1_r[2*p+1] <= MX_W'(d_r) * MX_W'(signed'({1'b0, ref_r[2*p+1]}));
    end
  end

  // Stage 5: round to 1/16 pixel and take off the observed point
  always_ff @(posedge clk) begin
    for (int q = 0; q < NPTS; q++) begin
      u_r[q] <= U_W'((W5'(m0_r[q]) + W5'(m1_r[q]) + RND_U) >>> (TF - 4))
                - U_W'(signed'({1'b0, obs_r[q], 4'b0000}));
    end
  end

  // Stage 6: squares
  always_ff @(posedge clk) begin
    for (int q = 0; q < NPTS; q++) sq_r[q] <= unsigned'(SQ_W'(u_r[q]) * SQ_W'(u_r[q]));
  end

  // Stage 7: sum and saturate
  always_ff @(posedge clk) begin
    logic [SUM_W-1:0] t;
    t = '0;
    for (int q = 0; q < NPTS; q++) t = t + SUM_W'(sq_r[q]);
    sum_r <= (t > SUM_W'(ERR_MAX)) ? ERR_MAX : t[ERR_W-1:0];
  end

  assign take_first = vld_r[PIPE_D-1] && first_r[PIPE_D-1];

  // Keep the strict minimum; the first triple of a stage always wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= ERR_MAX;
      best_r <= '0;
    end else if (take_first || (vld_r[PIPE_D-1] && (sum_r < low_r))) begin
      low_r  <= sum_r;
      best_r <= tag_r[PIPE_D-1];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.first  <= best_r.a1;
      res.second <= best_r.a2;
      res.third  <= best_r.a3;
      res.err    <= low_r;
    end
  end

  assign sts.busy = |vld_r;
  assign sts.best = best_r;

  `ASSERT_CLK(a_stage_first_taken, take_first |=> (low_r == $past(sum_r)))

endmodule
